// ===== rtl/core/lfbp_pkg.sv =====
package lfbp_pkg;

   localparam int MAX_BUFFERS_DEF = 8;
   localparam int MAX_READERS_DEF = 15;

   localparam logic [3:0] COUNT_RESET = 4'd3;

   typedef enum logic [1:0] {
      OP_ACQ_READ  = 2'd0,
      OP_ACQ_WRITE = 2'd1,
      OP_REL_READ  = 2'd2,
      OP_REL_WRITE = 2'd3
   } lfbp_op_type;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NONE   = 2'd1;
   localparam logic [1:0] ST_BADIDX = 2'd2;

   typedef enum logic {
      S_IDLE,
      S_EVAL
   } lfbp_state_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [2:0] buffer_index;
   } lfbp_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] granted_index;
   } lfbp_rsp_type;

   typedef struct packed {
      logic         done;
      lfbp_rsp_type rsp;
   } lfbp_done_type;

endpackage

// ===== rtl/core/latest_frame_buffer_pool.sv =====
// result path: a rejected index or a refused read on a latest buffer beyond the count
// goes from the accept straight to the result register; acquire-read and releases pass
// the evaluate state first; acquire-write stays in the evaluate state for each buffer
// scanned (at most the buffer count); one item in flight, next accept in the strobe cycle
// reset: synchronous, clears all locks, reader counts and latest index, count returns to 3
// the result strobe lasts one cycle and the receiver cannot stall it
module latest_frame_buffer_pool import lfbp_pkg::*; #(
   parameter int MAX_BUFFERS = MAX_BUFFERS_DEF,
   parameter int MAX_READERS = MAX_READERS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  lfbp_req_type req_data,
   output logic         rsp_valid,
   output lfbp_rsp_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [3:0]   csr_data
);

   logic [3:0]    count_ff;
   logic          rsp_valid_ff;
   lfbp_rsp_type  rsp_data_ff;
   lfbp_done_type done;

   lfbp_ctrl #(
      .MAX_BUFFERS (MAX_BUFFERS),
      .MAX_READERS (MAX_READERS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req          (req_data),
      .buffer_count (count_ff),
      .busy         (busy),
      .done         (done)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            count_ff <= csr_data;
         end
         rsp_valid_ff <= done.done;
      end
      rsp_data_ff <= done.rsp;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_BADIDX)
      else $error("result beat with undefined status");

   a_grant_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.granted_index == 3'd0)
      else $error("failed operation carries a granted index");

   a_accept_progress : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted beat neither in progress nor answered");

   a_no_strobe_busy : assert property (@(posedge clock) disable iff (reset)
      busy && $past(busy) |-> !rsp_valid)
      else $error("result beat while an operation is still running");

endmodule

// ===== rtl/core/lfbp_ram.sv =====
module lfbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/lfbp_ctrl.sv =====
module lfbp_ctrl import lfbp_pkg::*; #(
   parameter int MAX_BUFFERS = MAX_BUFFERS_DEF,
   parameter int MAX_READERS = MAX_READERS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  lfbp_req_type  req,
   input  logic [3:0]    buffer_count,
   output logic          busy,
   output lfbp_done_type done
);

   localparam int AW = $clog2(MAX_BUFFERS);
   localparam int RW = $clog2(MAX_READERS + 1);
   localparam int DW = RW + 1;

   lfbp_state_type state_ff, state_in;
   lfbp_op_type    op_ff, op_in;
   logic [2:0]     idx_ff, idx_in;
   logic [3:0]     n_ff, n_in;
   logic [3:0]     pos_ff, pos_in;
   logic [3:0]     left_ff, left_in;
   logic [2:0]     latest_ff, latest_in;
   logic [MAX_BUFFERS-1:0] valid_ff;
   logic           rd_valid_ff;

   logic [AW-1:0]  rd_addr;
   logic [DW-1:0]  rd_data;
   logic           wr_en;
   logic [DW-1:0]  wr_data;
   logic [3:0]     n_cur;
   logic [3:0]     cur;
   logic           cur_in_range;
   logic [DW-1:0]  entry;
   logic           entry_w;
   logic [RW-1:0]  entry_c;
   logic [3:0]     pos_next;

   lfbp_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_BUFFERS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(pos_ff)),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // saturate the configured count
   always_comb begin
      if (buffer_count < 4'd2) begin
         n_cur = 4'd2;
      end else if (32'(buffer_count) > MAX_BUFFERS) begin
         n_cur = 4'(MAX_BUFFERS);
      end else begin
         n_cur = buffer_count;
      end
   end

   assign cur          = {1'b0, latest_ff};
   assign cur_in_range = cur < n_cur;
   assign entry        = rd_valid_ff ? rd_data : '0;
   assign entry_w      = entry[DW-1];
   assign entry_c      = entry[RW-1:0];
   assign pos_next     = (pos_ff + 4'd1 == n_ff) ? 4'd0 : pos_ff + 4'd1;
   assign busy         = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      idx_in    = idx_ff;
      n_in      = n_ff;
      pos_in    = pos_ff;
      left_in   = left_ff;
      latest_in = latest_ff;
      rd_addr   = AW'(pos_ff);
      wr_en     = 1'b0;
      wr_data   = '0;
      done      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = lfbp_op_type'(req.opcode);
               idx_in = req.buffer_index;
               n_in   = n_cur;
               case (lfbp_op_type'(req.opcode))
                  OP_ACQ_READ: begin
                     if (!cur_in_range) begin
                        done.done       = 1'b1;
                        done.rsp.status = ST_NONE;
                     end else begin
                        pos_in   = cur;
                        left_in  = 4'd1;
                        rd_addr  = AW'(cur);
                        state_in = S_EVAL;
                     end
                  end
                  OP_ACQ_WRITE: begin
                     if (cur_in_range) begin
                        pos_in  = (cur + 4'd1 == n_cur) ? 4'd0 : cur + 4'd1;
                        left_in = n_cur - 4'd1;
                     end else begin
                        pos_in  = 4'd0;
                        left_in = n_cur;
                     end
                     rd_addr  = AW'(pos_in);
                     state_in = S_EVAL;
                  end
                  default: begin
                     if ({1'b0, req.buffer_index} >= n_cur) begin
                        done.done       = 1'b1;
                        done.rsp.status = ST_BADIDX;
                     end else begin
                        pos_in   = {1'b0, req.buffer_index};
                        left_in  = 4'd1;
                        rd_addr  = AW'(req.buffer_index);
                        state_in = S_EVAL;
                     end
                  end
               endcase
            end
         end
         S_EVAL: begin
            case (op_ff)
               OP_ACQ_READ: begin
                  done.done = 1'b1;
                  state_in  = S_IDLE;
                  if (!entry_w && entry_c < RW'(MAX_READERS)) begin
                     wr_en                  = 1'b1;
                     wr_data                = {1'b0, entry_c + RW'(1)};
                     done.rsp.status        = ST_OK;
                     done.rsp.granted_index = pos_ff[2:0];
                  end else begin
                     done.rsp.status = ST_NONE;
                  end
               end
               OP_ACQ_WRITE: begin
                  if (!entry_w && entry_c == '0) begin
                     wr_en                  = 1'b1;
                     wr_data                = {1'b1, {RW{1'b0}}};
                     done.done              = 1'b1;
                     done.rsp.status        = ST_OK;
                     done.rsp.granted_index = pos_ff[2:0];
                     state_in               = S_IDLE;
                  end else if (left_ff == 4'd1) begin
                     done.done       = 1'b1;
                     done.rsp.status = ST_NONE;
                     state_in        = S_IDLE;
                  end else begin
                     pos_in  = pos_next;
                     left_in = left_ff - 4'd1;
                     rd_addr = AW'(pos_next);
                  end
               end
               default: begin
                  wr_en = 1'b1;
                  if (entry_w) begin
                     wr_data = {1'b0, entry_c};
                  end else if (entry_c != '0) begin
                     wr_data = {1'b0, entry_c - RW'(1)};
                  end else begin
                     wr_data = '0;
                  end
                  if (op_ff == OP_REL_WRITE) begin
                     latest_in = idx_ff;
                  end
                  done.done       = 1'b1;
                  done.rsp.status = ST_OK;
                  state_in        = S_IDLE;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         latest_ff   <= '0;
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         latest_ff   <= latest_in;
         rd_valid_ff <= valid_ff[rd_addr];
         if (wr_en) begin
            valid_ff[AW'(pos_ff)] <= 1'b1;
         end
      end
      op_ff   <= op_in;
      idx_ff  <= idx_in;
      n_ff    <= n_in;
      pos_ff  <= pos_in;
      left_ff <= left_in;
   end

endmodule

// ===== test/latest_frame_buffer_pool_tb.sv =====
module latest_frame_buffer_pool_tb;
   import lfbp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_BUF = MAX_BUFFERS_DEF;
   localparam int MAX_RD  = MAX_READERS_DEF;

   typedef struct {
      lfbp_req_type req;
      int           gap;
   } pool_beat_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   lfbp_req_type req_data = '0;
   logic         rsp_valid;
   lfbp_rsp_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [3:0]   csr_data = 4'd0;

   // shadow of the pool state
   logic [3:0]   pool_size = COUNT_RESET;
   logic         write_locked [MAX_BUF];
   logic [3:0]   readers [MAX_BUF];
   logic [2:0]   latest_idx = 3'd0;

   pool_beat_type pending [$];
   lfbp_rsp_type expected_rsp [$];
   lfbp_rsp_type want;
   int           queued_count = 0;
   int           issued_count = 0;
   int           accepted_count = 0;
   int           gap_left = -1;
   int           failures = 0;

   latest_frame_buffer_pool dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   initial begin
      for (int i = 0; i < MAX_BUF; i++) begin
         write_locked[i] = 1'b0;
         readers[i] = 4'd0;
      end
   end

   function automatic int active_buffers();
      if (pool_size < 2) return 2;
      if (pool_size > MAX_BUF) return MAX_BUF;
      return pool_size;
   endfunction

   function automatic lfbp_rsp_type pool_outcome(lfbp_req_type req);
      int n;
      int cur;
      int first;
      int span;
      int j;
      lfbp_rsp_type r;
      n = active_buffers();
      cur = latest_idx;
      r.status = ST_NONE;
      r.granted_index = 3'd0;
      case (req.opcode)
         OP_ACQ_READ: begin
            if (cur < n && !write_locked[cur] && readers[cur] < MAX_RD) begin
               readers[cur]++;
               r.status = ST_OK;
               r.granted_index = 3'(cur);
            end
         end
         OP_ACQ_WRITE: begin
            // scan wraps past latest and never lands on it
            first = (cur < n) ? (cur + 1) % n : 0;
            span = (cur < n) ? n - 1 : n;
            for (int k = 0; k < span; k++) begin
               j = (first + k) % n;
               if (!write_locked[j] && readers[j] == 0) begin
                  write_locked[j] = 1'b1;
                  r.status = ST_OK;
                  r.granted_index = 3'(j);
                  break;
               end
            end
         end
         default: begin
            if (req.buffer_index >= n) begin
               r.status = ST_BADIDX;
            end else begin
               if (write_locked[req.buffer_index]) write_locked[req.buffer_index] = 1'b0;
               else if (readers[req.buffer_index] > 0) readers[req.buffer_index]--;
               if (req.opcode == OP_REL_WRITE) latest_idx = req.buffer_index;
               r.status = ST_OK;
            end
         end
      endcase
      return r;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && accepted_count != issued_count)) begin
         if (pending.size() > 0) begin
            if (gap_left < 0) gap_left = pending[0].gap;
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else begin
               req_data <= pending[0].req;
               start <= 1'b1;
               void'(pending.pop_front());
               issued_count++;
               gap_left = -1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected result: status %0d granted_index %0d",
                      rsp_data.status, rsp_data.granted_index);
               failures++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d actual %0d", want.status, rsp_data.status);
                  failures++;
               end
               if (rsp_data.granted_index !== want.granted_index) begin
                  $error("granted_index: expected %0d actual %0d",
                         want.granted_index, rsp_data.granted_index);
                  failures++;
               end
            end
         end
         if (start && !busy) begin
            expected_rsp.push_back(pool_outcome(req_data));
            accepted_count++;
         end
      end
   end

   task automatic queue_op(lfbp_op_type op, logic [2:0] idx, bit no_gaps);
      pool_beat_type b;
      b.req.opcode = op;
      b.req.buffer_index = idx;
      b.gap = no_gaps ? 0 : $urandom_range(0, 10);
      pending.push_back(b);
      queued_count++;
   endtask

   task automatic drain_pool();
      while (accepted_count != queued_count || expected_rsp.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_pool_size(logic [3:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      pool_size = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic lfbp_op_type random_op(bit read_heavy);
      int roll;
      roll = $urandom_range(0, 9);
      if (read_heavy) begin
         if (roll < 7) return OP_ACQ_READ;
         if (roll < 8) return OP_ACQ_WRITE;
         if (roll < 9) return OP_REL_READ;
         return OP_REL_WRITE;
      end
      if (roll < 3) return OP_ACQ_READ;
      if (roll < 5) return OP_ACQ_WRITE;
      if (roll < 8) return OP_REL_READ;
      return OP_REL_WRITE;
   endfunction

   task automatic random_beats(int count, bit read_heavy, bit no_gaps);
      lfbp_op_type op;
      logic [2:0] idx;
      for (int i = 0; i < count; i++) begin
         op = random_op(read_heavy);
         // mostly valid indexes, some beyond the count
         if (op == OP_ACQ_READ || op == OP_ACQ_WRITE || $urandom_range(0, 7) == 0)
            idx = 3'($urandom_range(0, 7));
         else
            idx = 3'($urandom_range(0, active_buffers() - 1));
         queue_op(op, idx, no_gaps);
      end
   endtask

   initial begin
      int sizes [12];
      sizes = '{2, 0, 15, 5, 1, 4, 9, 7, 6, 8, 2, 3};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset count of three: grants, refusals, stale releases, bad indexes
      queue_op(OP_ACQ_READ, 3'd5, 1'b0);
      queue_op(OP_ACQ_WRITE, 3'd0, 1'b0);
      queue_op(OP_ACQ_WRITE, 3'd7, 1'b0);
      queue_op(OP_ACQ_WRITE, 3'd2, 1'b0);
      queue_op(OP_REL_WRITE, 3'd1, 1'b0);
      queue_op(OP_ACQ_READ, 3'd0, 1'b0);
      queue_op(OP_ACQ_WRITE, 3'd3, 1'b0);
      queue_op(OP_REL_READ, 3'd0, 1'b0);
      queue_op(OP_REL_READ, 3'd0, 1'b0);
      queue_op(OP_REL_WRITE, 3'd0, 1'b0);
      queue_op(OP_ACQ_WRITE, 3'd6, 1'b0);
      queue_op(OP_REL_READ, 3'd3, 1'b0);
      queue_op(OP_REL_WRITE, 3'd7, 1'b0);
      queue_op(OP_REL_WRITE, 3'd2, 1'b0);
      queue_op(OP_REL_READ, 3'd1, 1'b0);
      queue_op(OP_ACQ_WRITE, 3'd4, 1'b0);
      queue_op(OP_ACQ_READ, 3'd1, 1'b0);
      drain_pool();

      // latest left beyond a lowered count
      write_pool_size(4'd8);
      queue_op(OP_ACQ_WRITE, 3'd0, 1'b1);
      queue_op(OP_REL_WRITE, 3'd7, 1'b1);
      queue_op(OP_REL_WRITE, 3'd7, 1'b1);
      drain_pool();
      write_pool_size(4'd3);
      queue_op(OP_ACQ_READ, 3'd0, 1'b0);
      queue_op(OP_ACQ_WRITE, 3'd0, 1'b0);
      queue_op(OP_ACQ_WRITE, 3'd0, 1'b0);
      drain_pool();

      foreach (sizes[p]) begin
         write_pool_size(4'(sizes[p]));
         random_beats(50, p % 3 == 0, p % 2 == 1);
         drain_pool();
         random_beats(50, p % 3 == 0, p % 2 == 1);
         drain_pool();
      end

      repeat (12) @(posedge clock);
      if (failures == 0) begin
         $display("latest_frame_buffer_pool_tb OK");
      end else begin
         $display("latest_frame_buffer_pool_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("latest_frame_buffer_pool_tb NOT OK");
      $finish;
   end

endmodule
